// File: hdl/waveform_minmax_column_plotter_unit_assert.svh
// ----------------------------------------------------------------------------
// waveform_minmax_column_plotter_unit_assert.svh
// Assertion macros used by the checker file of the plotter unit.
// ----------------------------------------------------------------------------
`ifndef WAVEFORM_MINMAX_COLUMN_PLOTTER_UNIT_ASSERT_SVH
`define WAVEFORM_MINMAX_COLUMN_PLOTTER_UNIT_ASSERT_SVH

// same-cycle implication, reset masked
`define WMCP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define WMCP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wmcp_pkg.sv
// ----------------------------------------------------------------------------
// wmcp_pkg
// Shared widths and register indexes of the waveform min/max column plotter.
// ----------------------------------------------------------------------------
package wmcp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COL_W    = 12;
    localparam int ROW_W    = 16;
    localparam int GAIN_W   = 16;
    localparam int FSA_W    = 15;
    localparam int DVD_W    = 36;   // |scaled| * height < 2^36, an even width
    localparam int CFG_A_W  = 3;
    localparam int CFG_D_W  = 16;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    localparam logic [CFG_A_W-1:0] CFG_GAIN     = 3'd0;
    localparam logic [CFG_A_W-1:0] CFG_FULL     = 3'd1;
    localparam logic [CFG_A_W-1:0] CFG_BASELINE = 3'd2;
    localparam logic [CFG_A_W-1:0] CFG_HEIGHT   = 3'd3;
    localparam logic [CFG_A_W-1:0] CFG_DENSE    = 3'd4;

endpackage

// File: hdl/wmcp_div.sv
// ----------------------------------------------------------------------------
// wmcp_div
// Iterative restoring divider, two quotient bits per cycle, unsigned.
// ----------------------------------------------------------------------------
module wmcp_div
    import wmcp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [FSA_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int ITER   = DVD_W / 2;
    localparam int CNT_W  = $clog2(ITER);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [FSA_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [FSA_W-1:0] r_dsr;

    logic [FSA_W:0]   t1;
    logic [FSA_W:0]   t2;
    logic [FSA_W-1:0] rem1;
    logic [FSA_W-1:0] n_rem;
    logic             q1;
    logic             q2;

    always_comb begin
        t1 = {r_rem, r_quo[DVD_W-1]};
        q1 = (t1 >= {1'b0, r_dsr});
        rem1 = q1 ? FSA_W'(t1 - {1'b0, r_dsr}) : t1[FSA_W-1:0];
        t2 = {rem1, r_quo[DVD_W-2]};
        q2 = (t2 >= {1'b0, r_dsr});
        n_rem = q2 ? FSA_W'(t2 - {1'b0, r_dsr}) : t2[FSA_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITER - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= (i_divisor == '0) ? FSA_W'(1) : i_divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[DVD_W-3:0], q1, q2};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hdl/waveform_minmax_column_plotter_unit.sv
// ----------------------------------------------------------------------------
// waveform_minmax_column_plotter_unit
// Maps samples to screen rows and emits plain or per-column min/max segments.
// ----------------------------------------------------------------------------
// channel   dir  fields (lsb first)
// s_axis    in   tdata: sample_amplitude[15:0], pixel_column[27:16]; tuser: start
// m_axis    out  tdata: from_x, from_y, to_x, to_y; tlast: last_segment
// cfg       in   addr: register index; data: value (always ready)
//
// Each sample emits none, one or four segments, after its row is set by the
// two-bit-per-cycle divider, which follows the multiply and scale states.
// Sync active-low reset restores the register defaults and clears tracking.
// Output stalls hold the sequencer in the emit state; no input is taken
// until every segment of the current sample has been loaded.
// ----------------------------------------------------------------------------
module waveform_minmax_column_plotter_unit
    import wmcp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,   // sample_amplitude, pixel_column
    input  logic                i_s_tuser,   // start_of_trace
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,   // from_x, from_y, to_x, to_y
    output logic                o_m_tlast,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_A_W-1:0]  i_cfg_addr,
    input  logic [CFG_D_W-1:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCALE, S_DIV, S_PLAN, S_EMIT, S_UPDATE
    } t_state;

    t_state r_state;

    logic [GAIN_W-1:0] r_gain;
    logic [FSA_W-1:0]  r_fsa;
    logic [COL_W-1:0]  r_base;
    logic [COL_W-1:0]  r_height;
    logic              r_dense;

    logic [SAMPLE_W-1:0] r_smag;
    logic                r_neg;
    logic [COL_W-1:0]    r_x;
    logic [31:0]         r_prod;
    logic signed [ROW_W-1:0] r_y;

    logic [1:0]              r_drawn;
    logic [COL_W-1:0]        r_prev_x;
    logic signed [ROW_W-1:0] r_prev_y;
    logic                    r_col_vld;
    logic [COL_W-1:0]        r_col_x;
    logic signed [ROW_W-1:0] r_col_first;
    logic signed [ROW_W-1:0] r_col_min;
    logic signed [ROW_W-1:0] r_col_max;

    logic       r_draw;
    logic       r_plain;
    logic       r_newcol;
    logic [1:0] r_k;
    logic [1:0] r_klast;

    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic                r_m_last;

    logic             div_start;
    logic             div_done;
    logic [DVD_W-1:0] div_dvd;
    logic [DVD_W-1:0] div_quo;

    logic signed [DVD_W:0]   q_s;
    logic signed [DVD_W+1:0] row_w;
    logic signed [ROW_W-1:0] row_sat;
    logic [SAMPLE_W-1:0]     in_sample;

    logic [COL_W-1:0]        seg_fx;
    logic signed [ROW_W-1:0] seg_fy;
    logic [COL_W-1:0]        seg_tx;
    logic signed [ROW_W-1:0] seg_ty;

    wmcp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (r_fsa),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // |scaled| * height, loaded into the divider in the scale cycle
    assign div_dvd   = DVD_W'(r_prod[31:8]) * DVD_W'(r_height);
    assign div_start = (r_state == S_SCALE);
    assign in_sample = i_s_tdata[SAMPLE_W-1:0];

    always_comb begin
        q_s   = r_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        row_w = $signed({{(DVD_W+2-COL_W){1'b0}}, r_base}) - (DVD_W+2)'(q_s);
        if (row_w > (DVD_W+2)'(32767)) begin
            row_sat = 16'sh7FFF;
        end else if (row_w < -(DVD_W+2)'(32768)) begin
            row_sat = 16'sh8000;
        end else begin
            row_sat = row_w[ROW_W-1:0];
        end
    end

    always_comb begin
        seg_fx = r_col_x;
        seg_fy = r_col_first;
        seg_tx = r_col_x;
        seg_ty = r_col_max;
        if (r_plain) begin
            seg_fx = r_prev_x;
            seg_fy = r_prev_y;
            seg_tx = r_x;
            seg_ty = r_y;
        end else begin
            case (r_k)
                2'd0: begin
                    seg_fy = r_col_first;
                    seg_ty = r_col_max;
                end
                2'd1: begin
                    seg_fy = r_col_first;
                    seg_ty = r_col_min;
                end
                2'd2: begin
                    seg_fy = r_col_max;
                    seg_tx = r_x;
                    seg_ty = r_y;
                end
                default: begin
                    seg_fy = r_col_min;
                    seg_tx = r_x;
                    seg_ty = r_y;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gain      <= GAIN_W'(256);
            r_fsa       <= FSA_W'(32767);
            r_base      <= '0;
            r_height    <= '0;
            r_dense     <= 1'b0;
            r_drawn     <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_col_vld   <= 1'b0;
            r_col_x     <= '0;
            r_col_first <= '0;
            r_col_min   <= '0;
            r_col_max   <= '0;
            r_m_valid   <= 1'b0;
            r_m_last    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_addr)
                    CFG_GAIN:     r_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_FULL:     r_fsa    <= i_cfg_data[FSA_W-1:0];
                    CFG_BASELINE: r_base   <= i_cfg_data[COL_W-1:0];
                    CFG_HEIGHT:   r_height <= i_cfg_data[COL_W-1:0];
                    CFG_DENSE:    r_dense  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // the emit state reloads the output register itself
            if (i_m_tready && r_state != S_EMIT) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_neg  <= in_sample[SAMPLE_W-1];
                        r_smag <= in_sample[SAMPLE_W-1] ? SAMPLE_W'(-in_sample) : in_sample;
                        r_x    <= i_s_tdata[SAMPLE_W +: COL_W];
                        if (i_s_tuser) begin
                            r_drawn     <= '0;
                            r_col_vld   <= 1'b0;
                            r_col_first <= '0;
                            r_col_min   <= '0;
                            r_col_max   <= '0;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 32'(r_smag) * 32'(r_gain);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_y     <= row_sat;
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_draw   <= (r_drawn != '0);
                    r_plain  <= !r_dense;
                    r_newcol <= !r_col_vld || (r_col_x != r_x);
                    r_k      <= '0;
                    if (r_drawn != '0 && !r_dense) begin
                        r_klast <= 2'd0;
                        r_state <= S_EMIT;
                    end else if (r_drawn != '0 && r_col_vld && r_col_x != r_x) begin
                        r_klast <= 2'd3;
                        r_state <= S_EMIT;
                    end else begin
                        r_klast <= 2'd0;
                        r_state <= S_UPDATE;
                    end
                end
                S_EMIT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {seg_ty, seg_tx, seg_fy, seg_fx};
                        r_m_last  <= (r_k == r_klast);
                        r_k       <= r_k + 2'd1;
                        if (r_k == r_klast) begin
                            r_state <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE: begin
                    if (r_drawn != 2'd2) begin
                        r_drawn <= r_drawn + 2'd1;
                    end
                    r_prev_x <= r_x;
                    r_prev_y <= r_y;
                    if (r_draw && !r_plain) begin
                        if (r_newcol) begin
                            r_col_vld   <= 1'b1;
                            r_col_x     <= r_x;
                            r_col_first <= r_y;
                            r_col_min   <= r_y;
                            r_col_max   <= r_y;
                        end else begin
                            if (r_y < r_col_min) r_col_min <= r_y;
                            if (r_y > r_col_max) r_col_max <= r_y;
                        end
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tlast   = r_m_last;
    assign o_cfg_ready = 1'b1;

endmodule

// File: hdl/wmcp_checker.sv
// ----------------------------------------------------------------------------
// wmcp_checker
// Port-level checks of the plotter unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "waveform_minmax_column_plotter_unit_assert.svh"

module wmcp_checker
    import wmcp_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic [S_DATA_W-1:0] i_s_tdata,   // sample_amplitude, pixel_column
    input logic                i_s_tuser,   // start_of_trace
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,   // from_x, from_y, to_x, to_y
    input logic                o_m_tlast,
    input logic                i_cfg_valid,
    input logic                o_cfg_ready,
    input logic [CFG_A_W-1:0]  i_cfg_addr,
    input logic [CFG_D_W-1:0]  i_cfg_data
);

    `WMCP_ASSERT_NEXT(a_busy_after_take, i_s_tvalid && o_s_tready, !o_s_tready, "ready right after a beat")
    `WMCP_ASSERT_NOW(a_busy_mid_burst, o_m_tvalid && !o_m_tlast, !o_s_tready, "ready mid-burst")
    `WMCP_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "output beat dropped")
    `WMCP_ASSERT_NEXT(a_out_stable, o_m_tvalid && !i_m_tready, $stable(o_m_tdata), "stalled data moved")

endmodule

bind waveform_minmax_column_plotter_unit wmcp_checker u_wmcp_checker (.*);
